FILE: rtl/stp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_pkg
// Shared sizes, codes and item types of the software timer pool.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int NUM_TIMERS = 32;
  localparam int IDX_W      = $clog2(NUM_TIMERS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int LINK_W     = IDX_W + 1;
  localparam int MAX_OWNERS = 16;
  localparam int OWN_W      = $clog2(MAX_OWNERS);
  localparam int MOD_STEPS  = 33;
  localparam int MSTEP_W    = $clog2(MOD_STEPS + 1);

  localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {IDX_W{1'b0}}};

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_KILL   = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [2:0] KIND_ADD_DONE    = 3'd0;
  localparam logic [2:0] KIND_CANCEL_DONE = 3'd1;
  localparam logic [2:0] KIND_KILL_DONE   = 3'd2;
  localparam logic [2:0] KIND_FIRE_DIE    = 3'd3;
  localparam logic [2:0] KIND_FIRE_REPEAT = 3'd4;
  localparam logic [2:0] KIND_CANCELLED   = 3'd5;
  localparam logic [2:0] KIND_TICK_DONE   = 3'd6;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] delay;
    logic        repeat_req;
    logic [15:0] owner;
    logic [31:0] user_word;
    logic [31:0] timer_handle;
    logic [31:0] step_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] handle_out;
    logic [31:0] elapsed;
    logic [15:0] owner_out;
    logic [31:0] user_out;
    logic        success;
    logic [5:0]  killed_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0]       handle;
    logic [15:0]       owner;
    logic [31:0]       user;
    logic [32:0]       rem;
    logic [31:0]       ivl;
    logic [LINK_W-1:0] prv;
    logic [LINK_W-1:0] nxt;
    logic              rep;
    logic              alive;
  } slot_rec_t;

  typedef struct packed {
    logic [15:0]      key;
    logic             wr_en;
    logic [OWN_W-1:0] wr_idx;
    logic             wr_vld;
    logic [15:0]      wr_owner;
    logic [31:0]      wr_handle;
  } own_req_t;

  typedef struct packed {
    logic             hit;
    logic [OWN_W-1:0] idx;
    logic [31:0]      head;
    logic             free_hit;
    logic [OWN_W-1:0] free_idx;
  } own_rsp_t;

  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [31:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] rem;
  } mod_rsp_t;

endpackage

FILE: rtl/stp_divmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_divmod
// Bit-serial remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module stp_divmod (
  input  logic              clk,
  input  logic              rst_n,
  input  stp_pkg::mod_req_t req,
  output stp_pkg::mod_rsp_t rsp
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [stp_pkg::MSTEP_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]                 acc_r, acc_nxt;
  logic [32:0]                 dvd_r, dvd_nxt;
  logic [31:0]                 dsr_r, dsr_nxt;
  logic [32:0]                 trial;

  assign trial = {acc_r, dvd_r[32]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        acc_nxt = 32'(trial - {1'b0, dsr_r});
      end else begin
        acc_nxt = trial[31:0];
      end
      dvd_nxt = {dvd_r[31:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == stp_pkg::MSTEP_W'(stp_pkg::MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = acc_r;

endmodule

FILE: rtl/stp_owner_tbl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_owner_tbl
// Owner table: head handle of each owner's list, searched by owner tag.
// ----------------------------------------------------------------------------
module stp_owner_tbl (
  input  logic              clk,
  input  logic              rst_n,
  input  stp_pkg::own_req_t req,
  output stp_pkg::own_rsp_t rsp
);

  logic [stp_pkg::MAX_OWNERS-1:0] vld_r;
  logic [15:0]                    own_r [stp_pkg::MAX_OWNERS];
  logic [31:0]                    hdl_r [stp_pkg::MAX_OWNERS];

  always_comb begin
    rsp.hit      = 1'b0;
    rsp.idx      = '0;
    rsp.free_hit = 1'b0;
    rsp.free_idx = '0;
    for (int k = stp_pkg::MAX_OWNERS - 1; k >= 0; k--) begin
      if (vld_r[k] && own_r[k] == req.key) begin
        rsp.hit = 1'b1;
        rsp.idx = stp_pkg::OWN_W'(k);
      end
      if (!vld_r[k]) begin
        rsp.free_hit = 1'b1;
        rsp.free_idx = stp_pkg::OWN_W'(k);
      end
    end
    rsp.head = hdl_r[rsp.idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_idx] <= req.wr_vld;
    end
    if (req.wr_en) begin
      own_r[req.wr_idx] <= req.wr_owner;
      hdl_r[req.wr_idx] <= req.wr_handle;
    end
  end

endmodule

FILE: rtl/stp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_core
// Sequencer around the slot memory and the lookup memory.
// ----------------------------------------------------------------------------
module stp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  stp_pkg::in_item_t  in_item,
  input  logic               out_free,
  output logic               emit,
  output stp_pkg::out_item_t emit_item,
  output stp_pkg::own_req_t  own_req,
  input  stp_pkg::own_rsp_t  own_rsp,
  output stp_pkg::mod_req_t  mod_req,
  input  stp_pkg::mod_rsp_t  mod_rsp
);

  localparam int NUM   = stp_pkg::NUM_TIMERS;
  localparam int IDX_W = stp_pkg::IDX_W;
  localparam int CNT_W = stp_pkg::CNT_W;
  localparam int LNK_W = stp_pkg::LINK_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_EMIT  = 5'd2;
  localparam logic [4:0] A_N1    = 5'd3;
  localparam logic [4:0] A_N2    = 5'd4;
  localparam logic [4:0] A_WR    = 5'd5;
  localparam logic [4:0] C_1     = 5'd6;
  localparam logic [4:0] C_2     = 5'd7;
  localparam logic [4:0] C_DONE  = 5'd8;
  localparam logic [4:0] K_L     = 5'd9;
  localparam logic [4:0] K_1     = 5'd10;
  localparam logic [4:0] K_2     = 5'd11;
  localparam logic [4:0] T_RD    = 5'd12;
  localparam logic [4:0] T_CALC  = 5'd13;
  localparam logic [4:0] T_UPD   = 5'd14;
  localparam logic [4:0] T_DIV   = 5'd15;
  localparam logic [4:0] T_SW    = 5'd16;
  localparam logic [4:0] T_SW2   = 5'd17;
  localparam logic [4:0] F_START = 5'd18;
  localparam logic [4:0] F_NRD1  = 5'd19;
  localparam logic [4:0] F_NRD2  = 5'd20;
  localparam logic [4:0] F_PREV  = 5'd21;
  localparam logic [4:0] F_PRD1  = 5'd22;
  localparam logic [4:0] F_PRD2  = 5'd23;
  localparam logic [4:0] E_START = 5'd24;
  localparam logic [4:0] E_COPY  = 5'd25;

  logic [4:0]                state_r, state_nxt;
  logic [4:0]                ret_r, ret_nxt;
  logic [4:0]                emit_next_r, emit_next_nxt;
  stp_pkg::out_item_t        emit_pl_r, emit_pl_nxt;
  stp_pkg::in_item_t         item_r, item_nxt;
  stp_pkg::slot_rec_t        rec_r, rec_nxt;
  logic [IDX_W-1:0]          s_r, s_nxt;
  logic [IDX_W-1:0]          tmp_r, tmp_nxt;
  logic [CNT_W-1:0]          i_r, i_nxt;
  logic [CNT_W-1:0]          size_r, size_nxt;
  logic [CNT_W-1:0]          orig_r, orig_nxt;
  logic [CNT_W-1:0]          live_r, live_nxt;
  logic [CNT_W-1:0]          free_r, free_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [CNT_W-1:0]          guard_r, guard_nxt;
  logic [15:0]               ver_r, ver_nxt;
  logic [LNK_W-1:0]          li_r, li_nxt;
  logic [LNK_W-1:0]          nli_r, nli_nxt;
  logic [33:0]               r_r, r_nxt;
  logic [stp_pkg::OWN_W-1:0] e_r, e_nxt;
  logic                      hit_r, hit_nxt;

  stp_pkg::slot_rec_t slot_mem [NUM];
  stp_pkg::slot_rec_t slot_q_r;
  logic [IDX_W-1:0]   slot_ra, slot_wa;
  logic               slot_we;
  stp_pkg::slot_rec_t slot_wd;

  logic [IDX_W-1:0] lkp_mem [NUM];
  logic [NUM-1:0]   lkp_vld_r;
  logic [IDX_W-1:0] lkp_q_r;
  logic [IDX_W-1:0] lkp_ra, lkp_wa, lkp_wd;
  logic             lkp_we;

  logic [IDX_W-1:0] stack_r [NUM];
  logic             push_en;
  logic [IDX_W-1:0] push_val;
  logic [CNT_W-1:0] push_pos, top_pos;
  logic [IDX_W-1:0] li_top;

  logic [33:0] r34, el34, neg_r;
  logic [31:0] el_sat, new_id;
  logic [CNT_W-1:0] last_slot;

  assign push_pos  = CNT_W'(NUM) - free_r - 1'b1;
  assign top_pos   = CNT_W'(NUM) - free_r;
  assign li_top    = stack_r[top_pos[IDX_W-1:0]];
  assign r34       = {slot_q_r.rem[32], slot_q_r.rem} - {2'b00, item_r.step_time};
  assign el34      = {2'b00, slot_q_r.ivl} - r34;
  assign el_sat    = (|el34[33:32]) ? 32'hffff_ffff : el34[31:0];
  assign neg_r     = 34'd0 - r_r;
  assign new_id    = {ver_r, {(16 - IDX_W){1'b0}}, li_r[IDX_W-1:0]};
  assign last_slot = live_r - 1'b1;
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    emit_next_nxt = emit_next_r;
    emit_pl_nxt   = emit_pl_r;
    item_nxt      = item_r;
    rec_nxt       = rec_r;
    s_nxt         = s_r;
    tmp_nxt       = tmp_r;
    i_nxt         = i_r;
    size_nxt      = size_r;
    orig_nxt      = orig_r;
    live_nxt      = live_r;
    free_nxt      = free_r;
    cnt_nxt       = cnt_r;
    guard_nxt     = guard_r;
    ver_nxt       = ver_r;
    li_nxt        = li_r;
    nli_nxt       = nli_r;
    r_nxt         = r_r;
    e_nxt         = e_r;
    hit_nxt       = hit_r;
    slot_ra       = '0;
    slot_we       = 1'b0;
    slot_wa       = s_r;
    slot_wd       = rec_r;
    lkp_ra        = '0;
    lkp_we        = 1'b0;
    lkp_wa        = '0;
    lkp_wd        = '0;
    push_en       = 1'b0;
    push_val      = '0;
    own_req       = '0;
    own_req.key   = (state_r == S_DISP) ? item_r.owner : rec_r.owner;
    mod_req       = '0;
    mod_req.dividend = neg_r[32:0];
    mod_req.divisor  = rec_r.ivl;
    emit          = 1'b0;
    emit_item     = emit_pl_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = S_DISP;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = emit_next_r;
        end
      end
      S_DISP: begin
        emit_pl_nxt      = '0;
        emit_pl_nxt.last = 1'b1;
        emit_next_nxt    = S_IDLE;
        case (item_r.op)
          stp_pkg::OP_ADD: begin
            if (live_r < CNT_W'(NUM) && free_r != '0 && (own_rsp.hit || own_rsp.free_hit)) begin
              li_nxt   = {1'b0, li_top};
              s_nxt    = live_r[IDX_W-1:0];
              live_nxt = live_r + 1'b1;
              free_nxt = free_r - 1'b1;
              hit_nxt  = own_rsp.hit;
              e_nxt    = own_rsp.hit ? own_rsp.idx : own_rsp.free_idx;
              nli_nxt  = {1'b0, own_rsp.head[IDX_W-1:0]};
              if (own_rsp.hit) begin
                lkp_ra    = own_rsp.head[IDX_W-1:0];
                state_nxt = A_N1;
              end else begin
                state_nxt = A_WR;
              end
            end else begin
              emit_pl_nxt.kind       = stp_pkg::KIND_ADD_DONE;
              emit_pl_nxt.handle_out = 32'hffff_ffff;
              state_nxt              = S_EMIT;
            end
          end
          stp_pkg::OP_CANCEL: begin
            if (item_r.timer_handle[15:IDX_W] == '0) begin
              lkp_ra    = item_r.timer_handle[IDX_W-1:0];
              state_nxt = C_1;
            end else begin
              emit_pl_nxt.kind       = stp_pkg::KIND_CANCEL_DONE;
              emit_pl_nxt.handle_out = item_r.timer_handle;
              state_nxt              = S_EMIT;
            end
          end
          stp_pkg::OP_KILL: begin
            if (own_rsp.hit) begin
              ver_nxt   = ver_r + 1'b1;
              li_nxt    = {1'b0, own_rsp.head[IDX_W-1:0]};
              e_nxt     = own_rsp.idx;
              cnt_nxt   = '0;
              guard_nxt = '0;
              state_nxt = K_L;
            end else begin
              emit_pl_nxt.kind      = stp_pkg::KIND_KILL_DONE;
              emit_pl_nxt.owner_out = item_r.owner;
              state_nxt             = S_EMIT;
            end
          end
          default: begin
            size_nxt  = live_r;
            i_nxt     = '0;
            state_nxt = T_RD;
          end
        endcase
      end
      A_N1: begin
        slot_ra   = lkp_q_r;
        tmp_nxt   = lkp_q_r;
        state_nxt = A_N2;
      end
      A_N2: begin
        slot_we     = 1'b1;
        slot_wa     = tmp_r;
        slot_wd     = slot_q_r;
        slot_wd.prv = li_r;
        state_nxt   = A_WR;
      end
      A_WR: begin
        slot_we        = 1'b1;
        slot_wa        = s_r;
        slot_wd.handle = new_id;
        slot_wd.owner  = item_r.owner;
        slot_wd.user   = item_r.user_word;
        slot_wd.rem    = {1'b0, item_r.delay};
        slot_wd.ivl    = item_r.delay;
        slot_wd.prv    = stp_pkg::LINK_NONE;
        slot_wd.nxt    = hit_r ? nli_r : stp_pkg::LINK_NONE;
        slot_wd.rep    = item_r.repeat_req;
        slot_wd.alive  = 1'b1;
        lkp_we         = 1'b1;
        lkp_wa         = li_r[IDX_W-1:0];
        lkp_wd         = s_r;
        own_req.wr_en     = 1'b1;
        own_req.wr_idx    = e_r;
        own_req.wr_vld    = 1'b1;
        own_req.wr_owner  = item_r.owner;
        own_req.wr_handle = new_id;
        emit_pl_nxt            = '0;
        emit_pl_nxt.kind       = stp_pkg::KIND_ADD_DONE;
        emit_pl_nxt.handle_out = new_id;
        emit_pl_nxt.success    = 1'b1;
        emit_pl_nxt.last       = 1'b1;
        emit_next_nxt          = S_IDLE;
        state_nxt              = S_EMIT;
      end
      C_1: begin
        if (CNT_W'(lkp_q_r) < live_r) begin
          slot_ra   = lkp_q_r;
          s_nxt     = lkp_q_r;
          state_nxt = C_2;
        end else begin
          emit_pl_nxt            = '0;
          emit_pl_nxt.kind       = stp_pkg::KIND_CANCEL_DONE;
          emit_pl_nxt.handle_out = item_r.timer_handle;
          emit_pl_nxt.last       = 1'b1;
          emit_next_nxt          = S_IDLE;
          state_nxt              = S_EMIT;
        end
      end
      C_2: begin
        emit_pl_nxt = '0;
        if (slot_q_r.handle == item_r.timer_handle && slot_q_r.alive) begin
          rec_nxt                = slot_q_r;
          emit_pl_nxt.kind       = stp_pkg::KIND_CANCELLED;
          emit_pl_nxt.handle_out = slot_q_r.handle;
          emit_pl_nxt.owner_out  = slot_q_r.owner;
          emit_pl_nxt.user_out   = slot_q_r.user;
          ret_nxt                = C_DONE;
          emit_next_nxt          = F_START;
        end else begin
          emit_pl_nxt.kind       = stp_pkg::KIND_CANCEL_DONE;
          emit_pl_nxt.handle_out = item_r.timer_handle;
          emit_pl_nxt.last       = 1'b1;
          emit_next_nxt          = S_IDLE;
        end
        state_nxt = S_EMIT;
      end
      C_DONE: begin
        ver_nxt                = ver_r + 1'b1;
        emit_pl_nxt            = '0;
        emit_pl_nxt.kind       = stp_pkg::KIND_CANCEL_DONE;
        emit_pl_nxt.handle_out = item_r.timer_handle;
        emit_pl_nxt.success    = 1'b1;
        emit_pl_nxt.last       = 1'b1;
        emit_next_nxt          = S_IDLE;
        state_nxt              = S_EMIT;
      end
      K_L: begin
        if (li_r[IDX_W] || guard_r == CNT_W'(NUM)) begin
          own_req.wr_en            = 1'b1;
          own_req.wr_idx           = e_r;
          emit_pl_nxt              = '0;
          emit_pl_nxt.kind         = stp_pkg::KIND_KILL_DONE;
          emit_pl_nxt.owner_out    = item_r.owner;
          emit_pl_nxt.killed_count = 6'(cnt_r);
          emit_pl_nxt.last         = 1'b1;
          emit_next_nxt            = S_IDLE;
          state_nxt                = S_EMIT;
        end else begin
          lkp_ra    = li_r[IDX_W-1:0];
          guard_nxt = guard_r + 1'b1;
          state_nxt = K_1;
        end
      end
      K_1: begin
        slot_ra   = lkp_q_r;
        s_nxt     = lkp_q_r;
        state_nxt = K_2;
      end
      K_2: begin
        if (free_r < CNT_W'(NUM)) begin
          push_en  = 1'b1;
          push_val = li_r[IDX_W-1:0];
          free_nxt = free_r + 1'b1;
        end
        li_nxt = slot_q_r.nxt;
        if (slot_q_r.alive) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        ret_nxt   = K_L;
        state_nxt = E_START;
      end
      T_RD: begin
        if (i_r == size_r) begin
          i_nxt     = '0;
          orig_nxt  = live_r;
          state_nxt = T_SW;
        end else begin
          slot_ra   = i_r[IDX_W-1:0];
          state_nxt = T_CALC;
        end
      end
      T_CALC: begin
        rec_nxt = slot_q_r;
        if (!slot_q_r.alive) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = T_RD;
        end else if (!r34[33] && r34 != '0) begin
          slot_we     = 1'b1;
          slot_wa     = i_r[IDX_W-1:0];
          slot_wd     = slot_q_r;
          slot_wd.rem = r34[32:0];
          i_nxt       = i_r + 1'b1;
          state_nxt   = T_RD;
        end else begin
          r_nxt                  = r34;
          emit_pl_nxt            = '0;
          emit_pl_nxt.kind       = slot_q_r.rep ? stp_pkg::KIND_FIRE_REPEAT
                                                : stp_pkg::KIND_FIRE_DIE;
          emit_pl_nxt.handle_out = slot_q_r.handle;
          emit_pl_nxt.elapsed    = el_sat;
          emit_pl_nxt.owner_out  = slot_q_r.owner;
          emit_pl_nxt.user_out   = slot_q_r.user;
          emit_next_nxt          = T_UPD;
          state_nxt              = S_EMIT;
        end
      end
      T_UPD: begin
        slot_wa = i_r[IDX_W-1:0];
        if (!rec_r.rep) begin
          slot_we       = 1'b1;
          slot_wd.rem   = r_r[32:0];
          slot_wd.alive = 1'b0;
          i_nxt         = i_r + 1'b1;
          state_nxt     = T_RD;
        end else if (rec_r.ivl == '0 || r_r == '0) begin
          slot_we     = 1'b1;
          slot_wd.rem = {1'b0, rec_r.ivl};
          i_nxt       = i_r + 1'b1;
          state_nxt   = T_RD;
        end else begin
          mod_req.start = 1'b1;
          state_nxt     = T_DIV;
        end
      end
      T_DIV: begin
        if (mod_rsp.done) begin
          slot_we     = 1'b1;
          slot_wa     = i_r[IDX_W-1:0];
          slot_wd.rem = {1'b0, rec_r.ivl - mod_rsp.rem};
          i_nxt       = i_r + 1'b1;
          state_nxt   = T_RD;
        end
      end
      T_SW: begin
        if (i_r < live_r) begin
          slot_ra   = i_r[IDX_W-1:0];
          state_nxt = T_SW2;
        end else begin
          if (live_r != orig_r) begin
            ver_nxt = ver_r + 1'b1;
          end
          emit_pl_nxt      = '0;
          emit_pl_nxt.kind = stp_pkg::KIND_TICK_DONE;
          emit_pl_nxt.last = 1'b1;
          emit_next_nxt    = S_IDLE;
          state_nxt        = S_EMIT;
        end
      end
      T_SW2: begin
        if (slot_q_r.alive) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = T_SW;
        end else begin
          rec_nxt   = slot_q_r;
          s_nxt     = i_r[IDX_W-1:0];
          ret_nxt   = T_SW;
          state_nxt = F_START;
        end
      end
      F_START: begin
        e_nxt   = own_rsp.idx;
        hit_nxt = own_rsp.hit;
        if (free_r < CNT_W'(NUM)) begin
          push_en  = 1'b1;
          push_val = rec_r.handle[IDX_W-1:0];
          free_nxt = free_r + 1'b1;
        end
        if (rec_r.prv == stp_pkg::LINK_NONE && rec_r.nxt == stp_pkg::LINK_NONE) begin
          own_req.wr_en  = own_rsp.hit;
          own_req.wr_idx = own_rsp.idx;
          state_nxt      = E_START;
        end else if (rec_r.nxt != stp_pkg::LINK_NONE) begin
          lkp_ra    = rec_r.nxt[IDX_W-1:0];
          state_nxt = F_NRD1;
        end else begin
          state_nxt = F_PREV;
        end
      end
      F_NRD1: begin
        slot_ra   = lkp_q_r;
        tmp_nxt   = lkp_q_r;
        state_nxt = F_NRD2;
      end
      F_NRD2: begin
        slot_we     = 1'b1;
        slot_wa     = tmp_r;
        slot_wd     = slot_q_r;
        slot_wd.prv = rec_r.prv;
        if (rec_r.prv == stp_pkg::LINK_NONE && hit_r) begin
          own_req.wr_en     = 1'b1;
          own_req.wr_idx    = e_r;
          own_req.wr_vld    = 1'b1;
          own_req.wr_owner  = rec_r.owner;
          own_req.wr_handle = slot_q_r.handle;
        end
        state_nxt = F_PREV;
      end
      F_PREV: begin
        if (rec_r.prv != stp_pkg::LINK_NONE) begin
          lkp_ra    = rec_r.prv[IDX_W-1:0];
          state_nxt = F_PRD1;
        end else begin
          state_nxt = E_START;
        end
      end
      F_PRD1: begin
        slot_ra   = lkp_q_r;
        tmp_nxt   = lkp_q_r;
        state_nxt = F_PRD2;
      end
      F_PRD2: begin
        slot_we     = 1'b1;
        slot_wa     = tmp_r;
        slot_wd     = slot_q_r;
        slot_wd.nxt = rec_r.nxt;
        state_nxt   = E_START;
      end
      E_START: begin
        if (CNT_W'(s_r) < last_slot) begin
          slot_ra   = last_slot[IDX_W-1:0];
          state_nxt = E_COPY;
        end else begin
          live_nxt  = last_slot;
          state_nxt = ret_r;
        end
      end
      E_COPY: begin
        slot_we   = 1'b1;
        slot_wa   = s_r;
        slot_wd   = slot_q_r;
        lkp_we    = 1'b1;
        lkp_wa    = slot_q_r.handle[IDX_W-1:0];
        lkp_wd    = s_r;
        live_nxt  = last_slot;
        state_nxt = ret_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot_q_r <= slot_mem[slot_ra];
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
  end

  always_ff @(posedge clk) begin
    lkp_q_r <= lkp_vld_r[lkp_ra] ? lkp_mem[lkp_ra] : '0;
    if (lkp_we) begin
      lkp_mem[lkp_wa] <= lkp_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lkp_vld_r <= '0;
      for (int k = 0; k < NUM; k++) begin
        stack_r[k] <= IDX_W'(k);
      end
    end else begin
      if (lkp_we) begin
        lkp_vld_r[lkp_wa] <= 1'b1;
      end
      if (push_en) begin
        stack_r[push_pos[IDX_W-1:0]] <= push_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      live_r  <= '0;
      free_r  <= CNT_W'(NUM);
      ver_r   <= '0;
    end else begin
      state_r <= state_nxt;
      live_r  <= live_nxt;
      free_r  <= free_nxt;
      ver_r   <= ver_nxt;
    end
    ret_r       <= ret_nxt;
    emit_next_r <= emit_next_nxt;
    emit_pl_r   <= emit_pl_nxt;
    item_r      <= item_nxt;
    rec_r       <= rec_nxt;
    s_r         <= s_nxt;
    tmp_r       <= tmp_nxt;
    i_r         <= i_nxt;
    size_r      <= size_nxt;
    orig_r      <= orig_nxt;
    cnt_r       <= cnt_nxt;
    guard_r     <= guard_nxt;
    li_r        <= li_nxt;
    nli_r       <= nli_nxt;
    r_r         <= r_nxt;
    e_r         <= e_nxt;
    hit_r       <= hit_nxt;
  end

  a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      ((CNT_W + 1)'(live_r) + (CNT_W + 1)'(free_r) == (CNT_W + 1)'(NUM)))
    else $error("live and free counts out of balance");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("item emitted into a full output register");

  a_mod_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mod_req.start |-> !mod_rsp.busy)
    else $error("remainder unit restarted while busy");

  a_erase_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == E_START) |-> (live_r != '0))
    else $error("erase with no live slot");

endmodule

FILE: rtl/software_timer_pool_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_pool_top
// Pool of one-shot and repeating timers with generational handles.
// ----------------------------------------------------------------------------
// One item is worked at a time. A kill walks the owner's list timer by timer.
// A tick reads each slot in use and updates the timers that fire, waiting on
// the bit-serial remainder unit for each repeating timer that fires with an
// overrun, then sweeps the slots and removes each dead timer. Timer records
// sit in a slot memory with a registered read and at most one read and one
// write per cycle. Each result item also waits for a free output register.
// No clearing pass follows reset.
module software_timer_pool_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  stp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output stp_pkg::out_item_t out_item
);

  stp_pkg::own_req_t  own_req;
  stp_pkg::own_rsp_t  own_rsp;
  stp_pkg::mod_req_t  mod_req;
  stp_pkg::mod_rsp_t  mod_rsp;
  logic               emit;
  stp_pkg::out_item_t emit_item;
  logic               out_free;
  logic               out_valid_r, out_valid_nxt;
  stp_pkg::out_item_t out_item_r, out_item_nxt;

  stp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_free  (out_free),
    .emit      (emit),
    .emit_item (emit_item),
    .own_req   (own_req),
    .own_rsp   (own_rsp),
    .mod_req   (mod_req),
    .mod_rsp   (mod_rsp)
  );

  stp_owner_tbl u_owner_tbl (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (own_req),
    .rsp   (own_rsp)
  );

  stp_divmod u_divmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = emit_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the software timer pool against a cycle-free model of its behavior.
// Directed items cover add, cancel, kill and tick with extreme fields, stale
// and out-of-range handles and a full owner table. Random items then mix the
// four operations over a small set of owners. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LINK_END = 'hffff;
  localparam int NT       = stp_pkg::NUM_TIMERS;
  localparam int NO       = stp_pkg::MAX_OWNERS;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  stp_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  stp_pkg::out_item_t out_item;

  software_timer_pool_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // timer pool shadow state
  logic [31:0] t_hdl [NT];
  logic [15:0] t_own [NT];
  logic [31:0] t_usr [NT];
  longint      t_rem [NT];
  logic [31:0] t_ivl [NT];
  int          t_prv [NT];
  int          t_nxt [NT];
  bit          t_rep [NT];
  bit          t_alive [NT];
  int          idx_slot [NT];
  int          free_idx [NT];
  int          free_cnt;
  int          live_cnt;
  bit          own_vld [NO];
  logic [31:0] own_head [NO];
  logic [15:0] gen;

  stp_pkg::out_item_t pending_events[$];
  int                 errors;
  bit                 calm;
  logic [15:0]        owner_set [20];
  logic [31:0]        old_handles[$];

  function automatic int slot_of(int li);
    if (li >= NT) return NT;
    return (idx_slot[li] < live_cnt) ? idx_slot[li] : NT;
  endfunction

  function automatic int owner_entry(logic [15:0] own);
    int s;
    for (int e = 0; e < NO; e++) begin
      if (own_vld[e]) begin
        s = slot_of(int'(own_head[e][15:0]));
        if (s < NT && t_own[s] == own) return e;
      end
    end
    return -1;
  endfunction

  function automatic void push_free(int li);
    if (free_cnt < NT) begin
      free_cnt++;
      free_idx[NT - free_cnt] = li;
    end
  endfunction

  function automatic void erase_swap(int s);
    int lst;
    int li;
    if (live_cnt == 0 || s >= live_cnt) return;
    lst = live_cnt - 1;
    if (s < lst) begin
      li = int'(t_hdl[lst][15:0]);
      t_hdl[s] = t_hdl[lst];
      t_own[s] = t_own[lst];
      t_usr[s] = t_usr[lst];
      t_rem[s] = t_rem[lst];
      t_ivl[s] = t_ivl[lst];
      t_prv[s] = t_prv[lst];
      t_nxt[s] = t_nxt[lst];
      t_rep[s] = t_rep[lst];
      t_alive[s] = t_alive[lst];
      if (li < NT) idx_slot[li] = s;
    end
    live_cnt = lst;
  endfunction

  function automatic void unlink_timer(int s);
    int  p;
    int  n;
    int  e;
    int  ns;
    int  ps;
    p = t_prv[s];
    n = t_nxt[s];
    e = owner_entry(t_own[s]);
    push_free(int'(t_hdl[s][15:0]));
    if (p == LINK_END && n == LINK_END) begin
      if (e >= 0) own_vld[e] = 1'b0;
    end else begin
      if (n != LINK_END) begin
        ns = slot_of(n);
        if (ns < NT) begin
          t_prv[ns] = p;
          if (p == LINK_END && e >= 0) begin
            own_vld[e] = 1'b1;
            own_head[e] = t_hdl[ns];
          end
        end
      end
      if (p != LINK_END) begin
        ps = slot_of(p);
        if (ps < NT) t_nxt[ps] = n;
      end
    end
    erase_swap(s);
  endfunction

  function automatic void post(logic [2:0] kind, logic [31:0] hdl, logic [31:0] el,
                               logic [15:0] own, logic [31:0] usr, logic suc,
                               logic [5:0] cnt);
    stp_pkg::out_item_t r;
    r.kind = kind;
    r.handle_out = hdl;
    r.elapsed = el;
    r.owner_out = own;
    r.user_out = usr;
    r.success = suc;
    r.killed_count = cnt;
    r.last = 1'b0;
    pending_events.push_back(r);
  endfunction

  function automatic void pool_reset();
    for (int i = 0; i < NT; i++) begin
      idx_slot[i] = 0;
      free_idx[i] = i;
    end
    for (int e = 0; e < NO; e++) begin
      own_vld[e] = 1'b0;
      own_head[e] = '0;
    end
    free_cnt = NT;
    live_cnt = 0;
    gen = '0;
  endfunction

  function automatic void pool_apply(stp_pkg::in_item_t it);
    int          e;
    int          fe;
    int          s;
    int          li;
    int          ns;
    int          cnt;
    int          guard;
    int          orig;
    int          n_live;
    bit          ok;
    logic [31:0] id;
    longint      r;
    longint      el;
    longint      over;
    case (it.op)
      stp_pkg::OP_ADD: begin
        e = owner_entry(it.owner);
        fe = -1;
        ok = live_cnt < NT && free_cnt > 0;
        if (ok && e < 0) begin
          for (int j = NO - 1; j >= 0; j--) if (!own_vld[j]) fe = j;
          ok = fe >= 0;
        end
        if (!ok) begin
          post(stp_pkg::KIND_ADD_DONE, 32'hffff_ffff, '0, '0, '0, 1'b0, '0);
        end else begin
          li = free_idx[NT - free_cnt];
          id = {gen, 16'(li)};
          s = live_cnt;
          free_cnt--;
          live_cnt++;
          t_hdl[s] = id;
          t_own[s] = it.owner;
          t_prv[s] = LINK_END;
          t_nxt[s] = LINK_END;
          if (e >= 0) begin
            ns = slot_of(int'(own_head[e][15:0]));
            if (ns < NT) t_prv[ns] = li;
            t_nxt[s] = int'(own_head[e][15:0]);
          end else begin
            e = fe;
          end
          idx_slot[li] = s;
          own_vld[e] = 1'b1;
          own_head[e] = id;
          t_ivl[s] = it.delay;
          t_rem[s] = longint'(it.delay);
          t_usr[s] = it.user_word;
          t_rep[s] = it.repeat_req;
          t_alive[s] = 1'b1;
          post(stp_pkg::KIND_ADD_DONE, id, '0, '0, '0, 1'b1, '0);
        end
      end
      stp_pkg::OP_CANCEL: begin
        s = slot_of(int'(it.timer_handle[15:0]));
        ok = s < NT && t_hdl[s] == it.timer_handle && t_alive[s];
        if (ok) begin
          t_alive[s] = 1'b0;
          post(stp_pkg::KIND_CANCELLED, t_hdl[s], '0, t_own[s], t_usr[s], 1'b0, '0);
          unlink_timer(s);
          gen++;
        end
        post(stp_pkg::KIND_CANCEL_DONE, it.timer_handle, '0, '0, '0, ok, '0);
      end
      stp_pkg::OP_KILL: begin
        e = owner_entry(it.owner);
        cnt = 0;
        if (e >= 0) begin
          li = int'(own_head[e][15:0]);
          guard = 0;
          gen++;
          while (li != LINK_END && guard < NT) begin
            s = slot_of(li);
            guard++;
            if (s >= NT) break;
            push_free(li);
            li = t_nxt[s];
            if (t_alive[s]) begin
              t_alive[s] = 1'b0;
              cnt++;
            end
            erase_swap(s);
          end
          own_vld[e] = 1'b0;
        end
        post(stp_pkg::KIND_KILL_DONE, '0, '0, it.owner, '0, 1'b0, 6'(cnt));
      end
      default: begin
        n_live = live_cnt;
        for (int i = 0; i < n_live; i++) begin
          if (!t_alive[i]) continue;
          r = t_rem[i] - longint'(it.step_time);
          t_rem[i] = r;
          if (r <= 0) begin
            el = longint'(t_ivl[i]) - r;
            if (el > 64'hffff_ffff) el = 64'hffff_ffff;
            post(t_rep[i] ? stp_pkg::KIND_FIRE_REPEAT : stp_pkg::KIND_FIRE_DIE,
                 t_hdl[i], el[31:0], t_own[i], t_usr[i], 1'b0, '0);
            if (!t_rep[i]) begin
              t_alive[i] = 1'b0;
            end else if (t_ivl[i] == 0 || r == 0) begin
              t_rem[i] = longint'(t_ivl[i]);
            end else begin
              over = -r;
              t_rem[i] = longint'(t_ivl[i]) - (over % longint'(t_ivl[i]));
            end
          end
        end
        orig = live_cnt;
        s = 0;
        while (s < live_cnt) begin
          if (!t_alive[s]) unlink_timer(s);
          else s++;
        end
        if (live_cnt != orig) gen++;
        post(stp_pkg::KIND_TICK_DONE, '0, '0, '0, '0, 1'b0, '0);
      end
    endcase
    pending_events[pending_events.size() - 1].last = 1'b1;
  endfunction

  // result side
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 22);
  end

  always @(negedge clk) begin
    stp_pkg::out_item_t x;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result item kind %0d", out_item.kind);
        errors++;
      end else begin
        x = pending_events.pop_front();
        if (out_item.kind !== x.kind) begin
          $error("kind: expected %0d, got %0d", x.kind, out_item.kind); errors++;
        end
        if (out_item.handle_out !== x.handle_out) begin
          $error("handle_out: expected %h, got %h", x.handle_out, out_item.handle_out);
          errors++;
        end
        if (out_item.elapsed !== x.elapsed) begin
          $error("elapsed: expected %h, got %h", x.elapsed, out_item.elapsed); errors++;
        end
        if (out_item.owner_out !== x.owner_out) begin
          $error("owner_out: expected %h, got %h", x.owner_out, out_item.owner_out);
          errors++;
        end
        if (out_item.user_out !== x.user_out) begin
          $error("user_out: expected %h, got %h", x.user_out, out_item.user_out); errors++;
        end
        if (out_item.success !== x.success) begin
          $error("success: expected %0d, got %0d", x.success, out_item.success); errors++;
        end
        if (out_item.killed_count !== x.killed_count) begin
          $error("killed_count: expected %0d, got %0d", x.killed_count,
                 out_item.killed_count);
          errors++;
        end
        if (out_item.last !== x.last) begin
          $error("last: expected %0d, got %0d", x.last, out_item.last); errors++;
        end
      end
    end
  end

  task automatic send_item(stp_pkg::in_item_t it);
    bit taken;
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    pool_apply(it);
  endtask

  function automatic stp_pkg::in_item_t noise_item(logic [1:0] op);
    stp_pkg::in_item_t it;
    it.op = op;
    it.delay = $urandom;
    it.repeat_req = $urandom_range(1);
    it.owner = $urandom;
    it.user_word = $urandom;
    it.timer_handle = $urandom;
    it.step_time = $urandom;
    return it;
  endfunction

  task automatic add_timer(logic [31:0] dly, bit rep, logic [15:0] own, logic [31:0] usr);
    stp_pkg::in_item_t it;
    it = noise_item(stp_pkg::OP_ADD);
    it.delay = dly;
    it.repeat_req = rep;
    it.owner = own;
    it.user_word = usr;
    send_item(it);
  endtask

  task automatic cancel_timer(logic [31:0] hdl);
    stp_pkg::in_item_t it;
    it = noise_item(stp_pkg::OP_CANCEL);
    it.timer_handle = hdl;
    send_item(it);
  endtask

  task automatic kill_owner(logic [15:0] own);
    stp_pkg::in_item_t it;
    it = noise_item(stp_pkg::OP_KILL);
    it.owner = own;
    send_item(it);
  endtask

  task automatic tick(logic [31:0] stp);
    stp_pkg::in_item_t it;
    it = noise_item(stp_pkg::OP_TICK);
    it.step_time = stp;
    send_item(it);
  endtask

  task automatic test_basic_ops();
    logic [31:0] h;
    add_timer(32'h0000_0000, 1'b1, 16'h0000, 32'h0000_0000);
    add_timer(32'hffff_ffff, 1'b1, 16'hffff, 32'hffff_ffff);
    add_timer(32'h0001_0000, 1'b0, 16'h0000, 32'h1234_5678);
    add_timer(32'h0000_8000, 1'b1, 16'h0001, 32'h8765_4321);
    tick(32'h0000_0000);
    tick(32'h0003_4000);
    h = t_hdl[live_cnt - 1];
    cancel_timer(h);
    cancel_timer(h);
    cancel_timer(32'h0000_0020);
    cancel_timer(32'hffff_ffff);
    kill_owner(16'h7777);
    kill_owner(16'h0000);
    tick(32'hffff_ffff);
  endtask

  task automatic test_owner_table_full();
    for (int k = 0; k <= NO; k++) begin
      add_timer(32'h0002_0000, 1'b0, 16'(16'h100 + k), $urandom);
    end
    tick(32'h0002_0000);
  endtask

  task automatic test_random_mix(int count);
    int          pick;
    int          pct_add;
    logic [31:0] dly;
    logic [31:0] h;
    for (int n = 0; n < count; n++) begin
      calm = (n >= count / 2 && n < count / 2 + 60);
      pct_add = ((n / 80) % 2 == 0) ? 55 : 30;
      pick = $urandom_range(99);
      if (pick < pct_add) begin
        case ($urandom_range(9))
          0: dly = $urandom;
          1: dly = 32'hffff_ffff;
          2: dly = 32'h0;
          default: dly = $urandom_range(32'h0004_0000);
        endcase
        add_timer(dly, $urandom_range(1), owner_set[$urandom_range(19)], $urandom);
      end else if (pick < pct_add + 20) begin
        if (live_cnt > 0 && $urandom_range(9) < 7) begin
          h = t_hdl[$urandom_range(live_cnt - 1)];
          old_handles.push_back(h);
          if (old_handles.size() > 40) void'(old_handles.pop_front());
        end else if (old_handles.size() > 0 && $urandom_range(1)) begin
          h = old_handles[$urandom_range(old_handles.size() - 1)];
        end else begin
          h = $urandom;
        end
        cancel_timer(h);
      end else if (pick < pct_add + 28) begin
        kill_owner($urandom_range(9) == 0 ? 16'($urandom) : owner_set[$urandom_range(19)]);
      end else begin
        case ($urandom_range(9))
          0: tick($urandom);
          1: tick(32'h0);
          default: tick($urandom_range(32'h0002_0000));
        endcase
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    errors = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    pool_reset();
    owner_set[0] = 16'h0000;
    owner_set[1] = 16'hffff;
    for (int k = 2; k < 20; k++) owner_set[k] = $urandom;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_owner_table_full();
    test_random_mix(430);
    in_valid <= 1'b0;
    wait (pending_events.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("tb: failure");
    $finish;
  end

endmodule
